[design/assert_macros.svh]
// assertion macros used by the deque datapath
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CDR_ASSERT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define CDR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[design/cdr_pkg.sv]
// shared types and constants of the circular deque with rotate
// used by cdr_ctrl, cdr_dpath and the top level
package cdr_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int ELEM_W       = 32;
	localparam int OUT_CNT_W    = 7;
	localparam int DIV_CNT_W    = $clog2(ELEM_W);

	localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
	localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
	localparam logic [1:0] CMD_ROTATE     = 2'd2;
	localparam logic [1:0] CMD_DUMP       = 2'd3;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;
	localparam logic [1:0] STS_ELEM  = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_PUSH,
		ST_ROT_CHK,
		ST_DIV,
		ST_SPLIT,
		ST_COPY_A,
		ST_COPY_B,
		ST_DUMP_CHK,
		ST_DUMP_RD,
		ST_DUMP_OUT,
		ST_RESP
	} cdr_state_t;

	// controller to datapath
	typedef struct packed {
		logic       cap_in;
		logic       do_push;
		logic       set_status;
		logic [1:0] status;
		logic       div_init;
		logic       div_step;
		logic       copy_init;
		logic       rd_ring_a;
		logic       rd_scratch_b;
		logic       idx_clr;
		logic       dump_rd;
		logic       dump_next;
		logic       emit_resp;
		logic       emit_elem;
	} cdr_ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       full;
		logic       count_zero;
		logic       count_le1;
		logic       amt_skip;
		logic       div_done;
		logic       rem_zero;
		logic       idx_last;
		logic       out_free;
	} cdr_stat_t;

endpackage

[design/cdr_ctrl.sv]
// controller state machine of the circular deque
// depends on cdr_pkg; drives cdr_dpath through cdr_ctrl_t
module cdr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  cdr_pkg::cdr_stat_t sts,
	output cdr_pkg::cdr_ctrl_t ctl
);

	cdr_pkg::cdr_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			cdr_pkg::ST_IDLE: begin
				if (s_tvalid) state_nxt = cdr_pkg::ST_DECODE;
			end
			cdr_pkg::ST_DECODE: begin
				case (sts.cmd)
					cdr_pkg::CMD_PUSH_FRONT: state_nxt = cdr_pkg::ST_PUSH;
					cdr_pkg::CMD_PUSH_BACK:  state_nxt = cdr_pkg::ST_PUSH;
					cdr_pkg::CMD_ROTATE:     state_nxt = cdr_pkg::ST_ROT_CHK;
					default:                 state_nxt = cdr_pkg::ST_DUMP_CHK;
				endcase
			end
			cdr_pkg::ST_PUSH: state_nxt = cdr_pkg::ST_RESP;
			cdr_pkg::ST_ROT_CHK: begin
				if (sts.amt_skip || sts.count_le1) state_nxt = cdr_pkg::ST_RESP;
				else state_nxt = cdr_pkg::ST_DIV;
			end
			cdr_pkg::ST_DIV: begin
				if (sts.div_done) state_nxt = cdr_pkg::ST_SPLIT;
			end
			cdr_pkg::ST_SPLIT: begin
				if (sts.rem_zero) state_nxt = cdr_pkg::ST_RESP;
				else state_nxt = cdr_pkg::ST_COPY_A;
			end
			cdr_pkg::ST_COPY_A: begin
				if (sts.idx_last) state_nxt = cdr_pkg::ST_COPY_B;
			end
			cdr_pkg::ST_COPY_B: begin
				if (sts.idx_last) state_nxt = cdr_pkg::ST_RESP;
			end
			cdr_pkg::ST_DUMP_CHK: begin
				if (sts.count_zero) state_nxt = cdr_pkg::ST_RESP;
				else state_nxt = cdr_pkg::ST_DUMP_RD;
			end
			cdr_pkg::ST_DUMP_RD: state_nxt = cdr_pkg::ST_DUMP_OUT;
			cdr_pkg::ST_DUMP_OUT: begin
				if (sts.out_free) begin
					if (sts.idx_last) state_nxt = cdr_pkg::ST_IDLE;
					else state_nxt = cdr_pkg::ST_DUMP_RD;
				end
			end
			cdr_pkg::ST_RESP: begin
				if (sts.out_free) state_nxt = cdr_pkg::ST_IDLE;
			end
			default: state_nxt = cdr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		s_tready = 1'b0;
		case (state_q)
			cdr_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				ctl.cap_in = s_tvalid;
			end
			cdr_pkg::ST_PUSH: begin
				ctl.set_status = 1'b1;
				if (sts.full) begin
					ctl.status = cdr_pkg::STS_FULL;
				end else begin
					ctl.status = cdr_pkg::STS_OK;
					ctl.do_push = 1'b1;
				end
			end
			cdr_pkg::ST_ROT_CHK: begin
				ctl.set_status = 1'b1;
				ctl.status = cdr_pkg::STS_OK;
				ctl.div_init = !(sts.amt_skip || sts.count_le1);
			end
			cdr_pkg::ST_DIV: ctl.div_step = 1'b1;
			cdr_pkg::ST_SPLIT: ctl.copy_init = !sts.rem_zero;
			cdr_pkg::ST_COPY_A: ctl.rd_ring_a = 1'b1;
			cdr_pkg::ST_COPY_B: ctl.rd_scratch_b = 1'b1;
			cdr_pkg::ST_DUMP_CHK: begin
				ctl.set_status = sts.count_zero;
				ctl.status = cdr_pkg::STS_EMPTY;
				ctl.idx_clr = 1'b1;
			end
			cdr_pkg::ST_DUMP_RD: ctl.dump_rd = 1'b1;
			cdr_pkg::ST_DUMP_OUT: begin
				ctl.emit_elem = sts.out_free;
				ctl.dump_next = sts.out_free;
			end
			cdr_pkg::ST_RESP: ctl.emit_resp = sts.out_free;
			default: ctl = '0;
		endcase
	end

endmodule

[design/cdr_dpath.sv]
// datapath of the circular deque: ring and scratch memories, indices,
// serial remainder unit and output register; depends on cdr_pkg
`include "assert_macros.svh"

module cdr_dpath #(
	parameter int CAPACITY = cdr_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [63:0]       s_tdata,  // value, shift_amount
	input  logic [1:0]        s_tuser,  // cmd
	input  cdr_pkg::cdr_ctrl_t ctl,
	output cdr_pkg::cdr_stat_t sts,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata,  // element, element_count, zero pad
	output logic [1:0]        m_tuser,  // status
	output logic              m_tlast
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int EW    = cdr_pkg::ELEM_W;
	localparam int DCW   = cdr_pkg::DIV_CNT_W;

	logic [EW-1:0] ring_mem [CAPACITY];
	logic [EW-1:0] scr_mem [CAPACITY];

	logic [1:0]                  cmd_q;
	logic [EW-1:0]               value_q;
	logic [EW-1:0]               amt_q;
	logic [IDX_W-1:0]            head_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            rem_q;
	logic [DCW-1:0]              step_q;
	logic [1:0]                  status_q;
	logic [CNT_W-1:0]            idx_q;
	logic [CNT_W-1:0]            pos_q;
	logic [EW-1:0]               ring_rd_q;
	logic [EW-1:0]               scr_rd_q;
	logic                        scr_wr_s1;
	logic                        ring_wr_s1;
	logic [IDX_W-1:0]            wr_addr_s1;
	logic                        out_valid_q;
	logic [EW-1:0]               out_elem_q;
	logic [cdr_pkg::OUT_CNT_W-1:0] out_cnt_q;
	logic [1:0]                  out_sts_q;
	logic                        out_last_q;

	logic [CNT_W-1:0]            slot_pos;
	logic [IDX_W-1:0]            slot_idx;
	logic [SUM_W-1:0]            slot_sum;
	logic [IDX_W-1:0]            head_dec;
	logic [CNT_W:0]              rem_sh;
	logic [CNT_W:0]              rem_sub;
	logic [CNT_W-1:0]            idx_nxt;
	logic [CNT_W-1:0]            pos_nxt;
	logic [CNT_W+cdr_pkg::OUT_CNT_W-1:0] cnt_ext;
	logic                        out_load;

	// slot of a position counted from the head
	always_comb begin
		if (ctl.rd_ring_a) slot_pos = pos_q;
		else if (ctl.do_push) slot_pos = count_q;
		else slot_pos = idx_q;
		slot_sum = SUM_W'(head_q) + SUM_W'(slot_pos);
		if (slot_sum >= SUM_W'(CAPACITY)) slot_sum = slot_sum - SUM_W'(CAPACITY);
		slot_idx = slot_sum[IDX_W-1:0];
	end

	assign head_dec = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - IDX_W'(1);
	assign rem_sh   = {rem_q, amt_q[EW-1]};
	assign rem_sub  = rem_sh - {1'b0, count_q};
	assign idx_nxt  = sts.idx_last ? '0 : idx_q + CNT_W'(1);
	assign pos_nxt  = (pos_q + CNT_W'(1) == count_q) ? '0 : pos_q + CNT_W'(1);
	assign cnt_ext  = {{cdr_pkg::OUT_CNT_W{1'b0}}, count_q};
	assign out_load = ctl.emit_resp || ctl.emit_elem;

	always_comb begin
		sts.cmd        = cmd_q;
		sts.full       = (count_q == CNT_W'(CAPACITY));
		sts.count_zero = (count_q == '0);
		sts.count_le1  = (count_q <= CNT_W'(1));
		sts.amt_skip   = amt_q[EW-1] || (amt_q == '0);
		sts.div_done   = (step_q == '0);
		sts.rem_zero   = (rem_q == '0);
		sts.idx_last   = (idx_q == count_q - CNT_W'(1));
		sts.out_free   = !out_valid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			scr_wr_s1   <= 1'b0;
			ring_wr_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.do_push) begin
				count_q <= count_q + CNT_W'(1);
				if (cmd_q == cdr_pkg::CMD_PUSH_FRONT) head_q <= head_dec;
			end
			scr_wr_s1  <= ctl.rd_ring_a;
			ring_wr_s1 <= ctl.rd_scratch_b;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// payload and counters
	always_ff @(posedge clk) begin
		if (ctl.cap_in) begin
			cmd_q   <= s_tuser;
			value_q <= s_tdata[EW-1:0];
			amt_q   <= s_tdata[2*EW-1:EW];
		end else if (ctl.div_step) begin
			amt_q <= {amt_q[EW-2:0], 1'b0};
		end
		if (ctl.set_status) status_q <= ctl.status;
		if (ctl.div_init) begin
			rem_q  <= '0;
			step_q <= DCW'(EW - 1);
		end else if (ctl.div_step) begin
			rem_q  <= (rem_sh >= {1'b0, count_q}) ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
			step_q <= step_q - DCW'(1);
		end
		if (ctl.idx_clr || ctl.copy_init) begin
			idx_q <= '0;
		end else if (ctl.rd_ring_a || ctl.rd_scratch_b || ctl.dump_next) begin
			idx_q <= idx_nxt;
		end
		if (ctl.copy_init) pos_q <= count_q - rem_q;
		else if (ctl.rd_ring_a) pos_q <= pos_nxt;
		if (ctl.rd_ring_a) wr_addr_s1 <= idx_q[IDX_W-1:0];
		else if (ctl.rd_scratch_b) wr_addr_s1 <= slot_idx;
		if (out_load) begin
			out_elem_q <= ctl.emit_elem ? ring_rd_q : '0;
			out_cnt_q  <= cnt_ext[cdr_pkg::OUT_CNT_W-1:0];
			out_sts_q  <= ctl.emit_elem ? cdr_pkg::STS_ELEM : status_q;
			out_last_q <= ctl.emit_elem ? sts.idx_last : 1'b1;
		end
	end

	// ring memory
	always_ff @(posedge clk) begin
		if (ctl.do_push) begin
			if (cmd_q == cdr_pkg::CMD_PUSH_FRONT) ring_mem[head_dec] <= value_q;
			else ring_mem[slot_idx] <= value_q;
		end else if (ring_wr_s1) begin
			ring_mem[wr_addr_s1] <= scr_rd_q;
		end
		if (ctl.rd_ring_a || ctl.dump_rd) ring_rd_q <= ring_mem[slot_idx];
	end

	// scratch memory
	always_ff @(posedge clk) begin
		if (scr_wr_s1) scr_mem[wr_addr_s1] <= ring_rd_q;
		if (ctl.rd_scratch_b) scr_rd_q <= scr_mem[idx_q[IDX_W-1:0]];
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_cnt_q, out_elem_q};
	assign m_tuser  = out_sts_q;
	assign m_tlast  = out_last_q;

	`CDR_ASSERT(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY))
	`CDR_ASSERT(a_head_bound, clk, arst_n, 1'b1, head_q <= IDX_W'(CAPACITY - 1))
	`CDR_ASSERT(a_full_resp, clk, arst_n, ctl.emit_resp && status_q == cdr_pkg::STS_FULL, count_q == CNT_W'(CAPACITY))
	`CDR_ASSERT_NEXT(a_rem_bound, clk, arst_n, ctl.div_step, rem_q < count_q)

endmodule

[design/circular_deque_with_rotate.sv]
// Circular deque of signed 32-bit elements (CAPACITY entries, default 64) with
// push front, push back, rotate right and dump. Each command is one request on
// the slave side; push and rotate give one status result, dump gives one result
// per element from head to tail (last flagged) or a single empty result. The
// block takes one request at a time. A rotate moves no element when k is not
// positive or the count is at most one; otherwise it forms the bit-serial
// remainder of k by the count, then, when the remainder is not zero, copies
// the elements out to a scratch memory and back, both passes through one
// read port per memory. A dump reads each element through the registered
// ring read. No clearing pass after reset. Output results sit in a register,
// so a stalled master side only holds the block once that register is full.
// depends on cdr_pkg, cdr_ctrl and cdr_dpath
module circular_deque_with_rotate #(
	parameter int CAPACITY = cdr_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // value[31:0], shift_amount[63:32]
	input  logic [1:0]  s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // element[31:0], element_count[38:32], zero pad
	output logic [1:0]  m_tuser,  // status
	output logic        m_tlast
);

	cdr_pkg::cdr_ctrl_t ctl;
	cdr_pkg::cdr_stat_t sts;

	cdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	cdr_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.ctl      (ctl),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[dv/circular_deque_with_rotate_tb.sv]
// self-checking testbench of circular_deque_with_rotate: directed and random requests
// with bursty sender and stalling receiver, checked against an in-bench deque mirror
// depends on cdr_pkg and circular_deque_with_rotate
module circular_deque_with_rotate_tb;

	localparam int DEPTH     = cdr_pkg::CAPACITY_DEF;
	localparam int HEAD_W    = $clog2(DEPTH);
	localparam int RAND_REQS = 380;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] value;
		logic [31:0] shift;
	} deque_req_t;

	typedef struct packed {
		logic [31:0] element;
		logic [6:0]  count;
		logic [1:0]  status;
		logic        last;
	} deque_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0]  s_tuser = cdr_pkg::CMD_PUSH_FRONT;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	deque_req_t    pending_reqs [$];
	deque_result_t resp_expect [$];

	logic signed [31:0] mirror_ring [DEPTH];
	logic [HEAD_W-1:0]  mirror_head = '0;
	logic [6:0]         mirror_count = '0;

	logic req_fire = 1'b0;
	int   reqs_taken = 0;
	int   mismatch_count = 0;

	circular_deque_with_rotate dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int slot_at(int pos);
		return (int'(mirror_head) + pos) % DEPTH;
	endfunction

	task automatic expect_status(input logic [1:0] sts);
		resp_expect.push_back('{element: '0, count: mirror_count, status: sts, last: 1'b1});
	endtask

	task automatic mirror_rotate(input logic [31:0] raw);
		logic signed [31:0] moved [DEPTH];
		int unsigned k;
		int unsigned split;
		if (raw[31] || raw == '0 || mirror_count <= 1)
			return;
		k = raw % mirror_count;
		if (k == 0)
			return;
		split = mirror_count - k;
		for (int i = 0; i < mirror_count; i++)
			moved[i] = mirror_ring[slot_at((i + split) % mirror_count)];
		for (int i = 0; i < mirror_count; i++)
			mirror_ring[slot_at(i)] = moved[i];
	endtask

	task automatic deque_apply(input logic [1:0] cmd, input logic [31:0] value,
		input logic [31:0] shift);
		case (cmd)
			cdr_pkg::CMD_PUSH_FRONT, cdr_pkg::CMD_PUSH_BACK: begin
				if (mirror_count >= DEPTH) begin
					expect_status(cdr_pkg::STS_FULL);
				end else begin
					if (cmd == cdr_pkg::CMD_PUSH_FRONT) begin
						mirror_head = mirror_head - 1'b1;
						mirror_ring[mirror_head] = value;
					end else begin
						mirror_ring[slot_at(mirror_count)] = value;
					end
					mirror_count = mirror_count + 1'b1;
					expect_status(cdr_pkg::STS_OK);
				end
			end
			cdr_pkg::CMD_ROTATE: begin
				mirror_rotate(shift);
				expect_status(cdr_pkg::STS_OK);
			end
			default: begin
				if (mirror_count == 0)
					expect_status(cdr_pkg::STS_EMPTY);
				for (int i = 0; i < mirror_count; i++)
					resp_expect.push_back('{element: mirror_ring[slot_at(i)],
						count: mirror_count, status: cdr_pkg::STS_ELEM,
						last: (i + 1 == mirror_count)});
			end
		endcase
	endtask

	// request acceptance and result checking
	always @(posedge clk) begin : check_results
		deque_result_t got;
		deque_result_t want;
		if (arst_n) begin
			req_fire <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				deque_apply(s_tuser, s_tdata[31:0], s_tdata[63:32]);
				reqs_taken++;
			end
			if (m_tvalid && m_tready) begin
				got = {m_tdata[31:0], m_tdata[38:32], m_tuser, m_tlast};
				if (resp_expect.size() == 0) begin
					mismatch_count++;
					$display("%0t: expected no result, actual element=%h count=%0d status=%0d last=%0b",
						$time, got.element, got.count, got.status, got.last);
				end else begin
					want = resp_expect.pop_front();
					if (got !== want) begin
						mismatch_count++;
						$write("%0t: expected element=%h count=%0d status=%0d last=%0b,",
							$time, want.element, want.count, want.status, want.last);
						$display(" actual element=%h count=%0d status=%0d last=%0b",
							got.element, got.count, got.status, got.last);
					end
				end
			end
		end
	end

	// sender: bursts of requests with random gaps
	always @(negedge clk) begin : drive_reqs
		deque_req_t retired;
		int burst_left;
		int gap_left;
		if (arst_n) begin
			if (req_fire)
				retired = pending_reqs.pop_front();
			if (!s_tvalid || req_fire) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tuser  <= pending_reqs[0].cmd;
					s_tdata  <= {pending_reqs[0].shift, pending_reqs[0].value};
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern in modes, plus one long hold-off
	always @(negedge clk) begin : drive_ready
		int rdy_mode;
		int mode_left;
		int hold_left;
		bit hold_done;
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && reqs_taken >= 150) begin
				hold_done = 1'b1;
				hold_left = 600;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rdy_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 200);
				end else begin
					mode_left--;
				end
				case (rdy_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	task automatic add_req(input logic [1:0] cmd, input logic [31:0] value,
		input logic [31:0] shift);
		pending_reqs.push_back('{cmd: cmd, value: value, shift: shift});
	endtask

	function automatic logic [31:0] pick_shift(int cnt);
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(1, cnt + 2);
			2: return '0;
			3: return cnt * $urandom_range(1, 4);
			4: return -$urandom_range(1, 100);
			default: return $urandom_range(1, 200);
		endcase
	endfunction

	initial begin
		int pick;
		int plan_count;
		logic [1:0] cmd_sel;

		// empty store, single element, extremes of value and rotate distance
		add_req(cdr_pkg::CMD_DUMP, 32'h0, 32'h0);
		add_req(cdr_pkg::CMD_ROTATE, 32'h0, 32'd7);
		add_req(cdr_pkg::CMD_PUSH_BACK, 32'h7fff_ffff, 32'hffff_ffff);
		add_req(cdr_pkg::CMD_ROTATE, 32'h0, 32'd5);
		add_req(cdr_pkg::CMD_DUMP, 32'hffff_ffff, 32'h0);
		add_req(cdr_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 32'h0);
		add_req(cdr_pkg::CMD_PUSH_BACK, 32'h0, 32'h0);
		add_req(cdr_pkg::CMD_PUSH_FRONT, 32'hffff_ffff, 32'h8000_0000);
		add_req(cdr_pkg::CMD_ROTATE, 32'h0, 32'h0);
		add_req(cdr_pkg::CMD_ROTATE, 32'h0, 32'h8000_0000);
		add_req(cdr_pkg::CMD_ROTATE, 32'h0, 32'hffff_ffff);
		add_req(cdr_pkg::CMD_ROTATE, 32'h0, 32'd4);
		add_req(cdr_pkg::CMD_ROTATE, 32'h0, 32'd1);
		add_req(cdr_pkg::CMD_ROTATE, 32'h0, 32'h7fff_ffff);
		add_req(cdr_pkg::CMD_DUMP, 32'h0, 32'h0);
		plan_count = 4;

		// random pushes, rotates and dumps; the store can grow to full, then pushes get refused
		for (int i = 0; i < RAND_REQS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				cmd_sel = $urandom_range(0, 1) ? cdr_pkg::CMD_PUSH_BACK : cdr_pkg::CMD_PUSH_FRONT;
				if (plan_count < DEPTH)
					plan_count++;
			end else if (pick < 80) begin
				cmd_sel = cdr_pkg::CMD_ROTATE;
			end else begin
				cmd_sel = cdr_pkg::CMD_DUMP;
			end
			add_req(cmd_sel, $urandom, pick_shift(plan_count));
		end

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || s_tvalid)
			@(posedge clk);
		while (resp_expect.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		if (mismatch_count == 0 && resp_expect.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#10000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/cdr_pkg.sv
design/cdr_ctrl.sv
design/cdr_dpath.sv
design/circular_deque_with_rotate.sv
dv/circular_deque_with_rotate_tb.sv
